[rtl/burp_pkg.sv]
// Shared constants, result type and scheme table for the broker URI parser.
package burp_pkg;

  localparam int BURP_MAX_URI_LENGTH = 1024;
  localparam int BURP_OFS_W          = 11;
  localparam int BURP_PORT_W         = 16;
  localparam int BURP_ERR_W          = 4;
  localparam int BURP_ACC_W          = 17;

  localparam logic [BURP_ERR_W-1:0] ERR_OK        = 4'd0;
  localparam logic [BURP_ERR_W-1:0] ERR_SCHEME    = 4'd1;
  localparam logic [BURP_ERR_W-1:0] ERR_AUTHORITY = 4'd2;
  localparam logic [BURP_ERR_W-1:0] ERR_IPV6      = 4'd3;
  localparam logic [BURP_ERR_W-1:0] ERR_HOST_PORT = 4'd4;
  localparam logic [BURP_ERR_W-1:0] ERR_BRACKETS  = 4'd5;
  localparam logic [BURP_ERR_W-1:0] ERR_EMPTY     = 4'd6;
  localparam logic [BURP_ERR_W-1:0] ERR_NUMERIC   = 4'd7;
  localparam logic [BURP_ERR_W-1:0] ERR_RANGE     = 4'd8;

  localparam logic [BURP_PORT_W-1:0] PORT_PLAIN  = 16'd1883;
  localparam logic [BURP_PORT_W-1:0] PORT_SECURE = 16'd8883;
  localparam logic [19:0]            PORT_LIMIT  = 20'd65535;

  localparam logic [3:0] SCHEME_LEN_PLAIN  = 4'd7;
  localparam logic [3:0] SCHEME_LEN_SECURE = 4'd8;
  localparam logic [3:0] SCHEME_S_PHASE    = 4'd4;

  typedef struct packed {
    logic [BURP_ERR_W-1:0]  error_code;
    logic                   secure;
    logic [BURP_PORT_W-1:0] port_number;
    logic [BURP_OFS_W-1:0]  host_start;
    logic [BURP_OFS_W-1:0]  host_length;
    logic                   too_long;
  } burp_result_t;

  function automatic logic [7:0] scheme_char(input logic secure, input logic [3:0] phase);
    logic [7:0] ch;
    ch = "m";
    if (secure) begin
      unique case (phase[2:0])
        3'd0: ch = "m";
        3'd1: ch = "q";
        3'd2: ch = "t";
        3'd3: ch = "t";
        3'd4: ch = "s";
        3'd5: ch = ":";
        3'd6: ch = "/";
        3'd7: ch = "/";
      endcase
    end else begin
      unique case (phase)
        4'd0: ch = "m";
        4'd1: ch = "q";
        4'd2: ch = "t";
        4'd3: ch = "t";
        4'd4: ch = ":";
        4'd5: ch = "/";
        4'd6: ch = "/";
        default: ch = "m";
      endcase
    end
    return ch;
  endfunction

  function automatic logic is_forbidden(input logic [7:0] c);
    return (c == "/") || (c == "?") || (c == "#") || (c == "@");
  endfunction

endpackage

[rtl/burp_if.sv]
// Valid/ready channel interfaces for URI bytes and parse results.
interface burp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] uri_char;
  logic       last_char;

  modport source (output valid, output uri_char, output last_char, input ready);
  modport sink   (input valid, input uri_char, input last_char, output ready);
endinterface

interface burp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  error_code;
  logic        secure;
  logic [15:0] port_number;
  logic [10:0] host_start;
  logic [10:0] host_length;
  logic        too_long;

  modport source (output valid, output error_code, output secure, output port_number,
                  output host_start, output host_length, output too_long, input ready);
  modport sink   (input valid, input error_code, input secure, input port_number,
                  input host_start, input host_length, input too_long, output ready);
endinterface

[rtl/burp_scan.sv]
// Per-byte URI scanner state and end-of-URI verdict.
module burp_scan
  import burp_pkg::*;
#(
  parameter int MAX_URI_LENGTH = BURP_MAX_URI_LENGTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   uri_char,
  input  logic         last_char,
  output burp_result_t result
);

  localparam int POS_W = $clog2(MAX_URI_LENGTH + 1);

  localparam logic [1:0] ACP_INSIDE = 2'd0;
  localparam logic [1:0] ACP_CLOSED = 2'd1;
  localparam logic [1:0] ACP_PORT   = 2'd2;
  localparam logic [1:0] ACP_STOP   = 2'd3;

  localparam logic [1:0] PF_NONE    = 2'd0;
  localparam logic [1:0] PF_NUMERIC = 2'd1;
  localparam logic [1:0] PF_RANGE   = 2'd2;

  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [3:0]            phase_r, phase_nxt;
  logic                  sfault_r, sfault_nxt;
  logic                  secure_r, secure_nxt;
  logic                  brk_r, brk_nxt;
  logic [1:0]            acp_r, acp_nxt;
  logic                  v6fault_r, v6fault_nxt;
  logic                  sepfault_r, sepfault_nxt;
  logic [1:0]            colons_r, colons_nxt;
  logic                  forbid_r, forbid_nxt;
  logic [POS_W-1:0]      hcount_r, hcount_nxt;
  logic [BURP_ACC_W-1:0] pacc_r, pacc_nxt;
  logic                  ppresent_r, ppresent_nxt;
  logic [1:0]            pfault_r, pfault_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [3:0]  slen;
  logic [3:0]  slen_n;
  logic        sec;
  logic        port_take;
  logic        digit_ok;
  logic [19:0] acc_ext;
  logic [19:0] prod;
  logic        colon_seen;

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    sfault_nxt   = sfault_r;
    secure_nxt   = secure_r;
    brk_nxt      = brk_r;
    acp_nxt      = acp_r;
    v6fault_nxt  = v6fault_r;
    sepfault_nxt = sepfault_r;
    colons_nxt   = colons_r;
    forbid_nxt   = forbid_r;
    hcount_nxt   = hcount_r;
    pacc_nxt     = pacc_r;
    ppresent_nxt = ppresent_r;
    pfault_nxt   = pfault_r;
    ovf_nxt      = ovf_r;
    port_take    = 1'b0;
    sec          = secure_r;
    slen         = secure_r ? SCHEME_LEN_SECURE : SCHEME_LEN_PLAIN;
    digit_ok     = (uri_char >= "0") && (uri_char <= "9");
    acc_ext      = 20'(pacc_r);
    prod         = (acc_ext << 3) + (acc_ext << 1) + 20'(uri_char - 8'("0"));

    if (pos_r >= POS_W'(MAX_URI_LENGTH)) begin
      ovf_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + 1'b1;
      if (!sfault_r) begin
        if (phase_r < slen) begin
          sec = secure_r | ((phase_r == SCHEME_S_PHASE) && (uri_char == "s"));
          secure_nxt = sec;
          if (uri_char != scheme_char(sec, phase_r)) begin
            sfault_nxt = 1'b1;
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
        end else begin
          if (is_forbidden(uri_char)) begin
            forbid_nxt = 1'b1;
          end
          if ((pos_r == POS_W'(slen)) && (uri_char == "[")) begin
            brk_nxt = 1'b1;
          end else if (brk_r) begin
            unique case (acp_r)
              ACP_INSIDE: begin
                if (uri_char == "]") begin
                  if (hcount_r == '0) begin
                    v6fault_nxt = 1'b1;
                  end
                  acp_nxt = ACP_CLOSED;
                end else begin
                  hcount_nxt = hcount_r + 1'b1;
                end
              end
              ACP_CLOSED: begin
                if (uri_char == ":") begin
                  acp_nxt = ACP_PORT;
                end else begin
                  sepfault_nxt = 1'b1;
                  acp_nxt      = ACP_STOP;
                end
              end
              ACP_PORT: port_take = 1'b1;
              ACP_STOP: ;
            endcase
          end else if (uri_char == ":") begin
            if (colons_r < 2'd2) begin
              colons_nxt = colons_r + 1'b1;
            end
          end else if (colons_r == 2'd0) begin
            hcount_nxt = hcount_r + 1'b1;
          end else if (colons_r == 2'd1) begin
            port_take = 1'b1;
          end
        end
      end
    end

    if (port_take) begin
      ppresent_nxt = 1'b1;
      if (pfault_r == PF_NONE) begin
        if (!digit_ok) begin
          pfault_nxt = PF_NUMERIC;
        end else begin
          pacc_nxt = prod[BURP_ACC_W-1:0];
          if (prod > PORT_LIMIT) begin
            pfault_nxt = PF_RANGE;
          end
        end
      end
    end
  end

  always_comb begin
    slen_n     = secure_nxt ? SCHEME_LEN_SECURE : SCHEME_LEN_PLAIN;
    colon_seen = brk_nxt ? (acp_nxt == ACP_PORT) : (colons_nxt == 2'd1);
    result     = '0;
    result.too_long = ovf_nxt;
    priority if (sfault_nxt || (phase_nxt < slen_n)) begin
      result.error_code = ERR_SCHEME;
    end else if ((pos_nxt == POS_W'(slen_n)) || forbid_nxt) begin
      result.error_code = ERR_AUTHORITY;
    end else if (brk_nxt && ((acp_nxt == ACP_INSIDE) || v6fault_nxt)) begin
      result.error_code = ERR_IPV6;
    end else if (brk_nxt && sepfault_nxt) begin
      result.error_code = ERR_HOST_PORT;
    end else if (!brk_nxt && (colons_nxt >= 2'd2)) begin
      result.error_code = ERR_BRACKETS;
    end else if ((hcount_nxt == '0) || (colon_seen && !ppresent_nxt)) begin
      result.error_code = ERR_EMPTY;
    end else if (colon_seen && (pfault_nxt == PF_NUMERIC)) begin
      result.error_code = ERR_NUMERIC;
    end else if (colon_seen && ((pfault_nxt == PF_RANGE) || (pacc_nxt == '0))) begin
      result.error_code = ERR_RANGE;
    end else begin
      result.error_code  = ERR_OK;
      result.secure      = secure_nxt;
      result.port_number = colon_seen ? pacc_nxt[BURP_PORT_W-1:0]
                                      : (secure_nxt ? PORT_SECURE : PORT_PLAIN);
      result.host_start  = BURP_OFS_W'(slen_n) + BURP_OFS_W'(brk_nxt);
      result.host_length = BURP_OFS_W'(hcount_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_char)) begin
      pos_r      <= '0;
      phase_r    <= '0;
      sfault_r   <= 1'b0;
      secure_r   <= 1'b0;
      brk_r      <= 1'b0;
      acp_r      <= ACP_INSIDE;
      v6fault_r  <= 1'b0;
      sepfault_r <= 1'b0;
      colons_r   <= '0;
      forbid_r   <= 1'b0;
      hcount_r   <= '0;
      pacc_r     <= '0;
      ppresent_r <= 1'b0;
      pfault_r   <= PF_NONE;
      ovf_r      <= 1'b0;
    end else if (step) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      sfault_r   <= sfault_nxt;
      secure_r   <= secure_nxt;
      brk_r      <= brk_nxt;
      acp_r      <= acp_nxt;
      v6fault_r  <= v6fault_nxt;
      sepfault_r <= sepfault_nxt;
      colons_r   <= colons_nxt;
      forbid_r   <= forbid_nxt;
      hcount_r   <= hcount_nxt;
      pacc_r     <= pacc_nxt;
      ppresent_r <= ppresent_nxt;
      pfault_r   <= pfault_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

[rtl/broker_uri_host_port_parser.sv]
// Broker URI parser: one byte per cycle in, one result per URI out.
// A result is registered once its last byte has passed the input register and scanner.
// Throughput: one byte per cycle; the input register stalls only when it holds a last
// byte while an earlier result waits in the output register and the sink is not ready.
// Reset: synchronous active-low rst_n clears the scanner state and both valid flags.
module broker_uri_host_port_parser
  import burp_pkg::*;
#(
  parameter int MAX_URI_LENGTH = BURP_MAX_URI_LENGTH
) (
  input  logic              clk,
  input  logic              rst_n,
  burp_in_if.sink           in_ch,
  burp_out_if.source        out_ch
);

  logic         s1_valid_r;
  logic [7:0]   char_r;
  logic         last_r;
  logic         out_valid_r;
  burp_result_t res_r;
  burp_result_t res;
  logic         adv;

  assign adv         = s1_valid_r && !(last_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  burp_scan #(
    .MAX_URI_LENGTH(MAX_URI_LENGTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .uri_char  (char_r),
    .last_char (last_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      char_r <= in_ch.uri_char;
      last_r <= in_ch.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_r) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.error_code  = res_r.error_code;
  assign out_ch.secure      = res_r.secure;
  assign out_ch.port_number = res_r.port_number;
  assign out_ch.host_start  = res_r.host_start;
  assign out_ch.host_length = res_r.host_length;
  assign out_ch.too_long    = res_r.too_long;

endmodule
